// ===== rtl/cesd_pkg.sv =====
// ----------------------------------------------------------------------------
// cesd_pkg
// shared types, character codes and lookup functions for the escape decoder
// ----------------------------------------------------------------------------
`default_nettype none

package cesd_pkg;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // character codes
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_LO_U   = 8'h75;
   localparam logic [7:0] CH_UP_U   = 8'h55;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // code point limits
   localparam logic [31:0] SURR_LO = 32'h0000_D800;
   localparam logic [31:0] SURR_HI = 32'h0000_DFFF;
   localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;

   // digit counts
   localparam logic [3:0] OCT_MAX_DIGITS = 4'd3;
   localparam logic [3:0] UCN_SHORT_LEN  = 4'd4;
   localparam logic [3:0] UCN_LONG_LEN   = 4'd8;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNKNOWN = 3'd1,
      ST_INCOMPL = 3'd2,
      ST_NOHEX   = 3'd3,
      ST_SHORT   = 3'd4,
      ST_BADCP   = 3'd5
   } status_type;

   // classified character, as handed from front to back
   typedef struct packed {
      logic       eot;
      logic [7:0] ch;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_oct;
      logic       is_simple;
      logic [6:0] simple_val;
      logic       is_x;
      logic       is_ucn_start;
      logic       ucn_long;
   } item_type;

   // one result
   typedef struct packed {
      logic [31:0] value;
      logic        is_ucn;
      status_type  status;
      logic        char_used;
   } result_type;

   function automatic logic hex_digit(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F)
          || (c >= CH_UP_A && c <= CH_UP_F);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - CH_ZERO;
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         v = c - CH_LO_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         v = c - CH_UP_A + 8'd10;
      end
      return v[3:0];
   endfunction

   // simple escapes: bit 7 flags a match, bits 6:0 give the value
   function automatic logic [7:0] simple_lookup(input logic [7:0] c);
      case (c)
         8'h27:   return {1'b1, 7'h27};
         8'h22:   return {1'b1, 7'h22};
         8'h3F:   return {1'b1, 7'h3F};
         8'h5C:   return {1'b1, 7'h5C};
         8'h61:   return {1'b1, 7'd7};
         8'h62:   return {1'b1, 7'd8};
         8'h66:   return {1'b1, 7'd12};
         8'h6E:   return {1'b1, 7'd10};
         8'h72:   return {1'b1, 7'd13};
         8'h74:   return {1'b1, 7'd9};
         8'h76:   return {1'b1, 7'd11};
         default: return 8'h00;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cesd_if.sv =====
// ----------------------------------------------------------------------------
// cesd channel interfaces
// valid/ready channels for characters in and decoded results out
// ----------------------------------------------------------------------------
`default_nettype none

interface cesd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, output ch, output end_of_text, input ready);
   modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface cesd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        is_ucn;
   logic [2:0]  status;
   logic        char_used;

   modport source (output valid, output value, output is_ucn, output status,
                   output char_used, input ready);
   modport sink   (input valid, input value, input is_ucn, input status,
                   input char_used, output ready);
endinterface

`default_nettype wire

// ===== rtl/cesd_front.sv =====
// ----------------------------------------------------------------------------
// cesd_front
// accepts characters and classifies them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_front (
   cesd_req_if.sink            req_chan,
   input  wire logic           q_ready,
   output logic                q_push,
   output cesd_pkg::item_type  q_item
);
   import cesd_pkg::*;

   logic [7:0] simple;

   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid && q_ready;
   assign simple         = simple_lookup(req_chan.ch);

   always_comb begin
      q_item              = '0;
      q_item.eot          = req_chan.end_of_text;
      q_item.ch           = req_chan.ch;
      // end of text never counts as a digit
      q_item.is_hex       = !req_chan.end_of_text && hex_digit(req_chan.ch);
      q_item.hex_val      = nibble_of(req_chan.ch);
      q_item.is_oct       = !req_chan.end_of_text && req_chan.ch >= CH_ZERO
                            && req_chan.ch <= CH_SEVEN;
      q_item.is_simple    = simple[7];
      q_item.simple_val   = simple[6:0];
      q_item.is_x         = (req_chan.ch == CH_X);
      q_item.is_ucn_start = (req_chan.ch == CH_LO_U) || (req_chan.ch == CH_UP_U);
      q_item.ucn_long     = (req_chan.ch == CH_UP_U);
   end

endmodule

`default_nettype wire

// ===== rtl/cesd_queue.sv =====
// ----------------------------------------------------------------------------
// cesd_queue
// small fifo of classified characters between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_queue #(
   parameter int unsigned DEPTH = cesd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cesd_pkg::item_type  push_item,
   output logic                     ready,
   input  wire logic                pop,
   output logic                     valid,
   output cesd_pkg::item_type       pop_item
);
   import cesd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign ready    = (count_ff != CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push  = push && ready;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cesd_back.sv =====
// ----------------------------------------------------------------------------
// cesd_back
// escape sequence state machine with registered result
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire cesd_pkg::item_type  q_item,
   output logic                     q_pop,
   output logic                     out_valid,
   output cesd_pkg::result_type     out_result,
   input  wire logic                out_ready
);
   import cesd_pkg::*;

   typedef enum logic [2:0] {
      MODE_FIRST = 3'd0,
      MODE_OCT   = 3'd1,
      MODE_HEX0  = 3'd2,
      MODE_HEX   = 3'd3,
      MODE_UCN   = 3'd4
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  count_ff, count_in;
   logic        long_ff, long_in;
   logic        valid_ff, valid_in;
   result_type  result_ff, result_in;

   logic        emit;
   result_type  res;
   logic [31:0] acc_oct, acc_hex;
   logic [3:0]  count_inc;
   logic        ucn_done, bad_cp;

   assign q_pop      = q_valid && (!valid_ff || out_ready);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   assign acc_oct   = {acc_ff[28:0], q_item.ch[2:0]};
   assign acc_hex   = {acc_ff[27:0], q_item.hex_val};
   assign count_inc = count_ff + 4'd1;
   assign ucn_done  = long_ff ? (count_inc >= UCN_LONG_LEN) : (count_inc >= UCN_SHORT_LEN);
   assign bad_cp    = (acc_hex >= SURR_LO && acc_hex <= SURR_HI) || (acc_hex > CP_MAX);

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      long_in  = long_ff;
      emit     = 1'b0;
      res      = '{value: 32'd0, is_ucn: 1'b0, status: ST_OK, char_used: 1'b0};

      case (mode_ff)
         MODE_OCT: begin
            if (!q_item.is_oct) begin
               emit      = 1'b1;
               res.value = acc_ff;
            end else begin
               acc_in   = acc_oct;
               count_in = count_inc;
               if (count_inc >= OCT_MAX_DIGITS) begin
                  emit          = 1'b1;
                  res.value     = acc_oct;
                  res.char_used = 1'b1;
               end
            end
         end
         MODE_HEX0: begin
            if (!q_item.is_hex) begin
               emit       = 1'b1;
               res.value  = {24'd0, CH_X};
               res.status = ST_NOHEX;
            end else begin
               acc_in  = {28'd0, q_item.hex_val};
               mode_in = MODE_HEX;
            end
         end
         MODE_HEX: begin
            if (!q_item.is_hex) begin
               emit      = 1'b1;
               res.value = acc_ff;
            end else begin
               acc_in = acc_hex;
            end
         end
         MODE_UCN: begin
            if (!q_item.is_hex) begin
               emit       = 1'b1;
               res.value  = acc_ff;
               res.is_ucn = 1'b1;
               res.status = ST_SHORT;
            end else begin
               acc_in   = acc_hex;
               count_in = count_inc;
               if (ucn_done) begin
                  emit          = 1'b1;
                  res.value     = acc_hex;
                  res.is_ucn    = 1'b1;
                  res.status    = bad_cp ? ST_BADCP : ST_OK;
                  res.char_used = 1'b1;
               end
            end
         end
         default: begin
            // first character after the backslash
            if (q_item.eot) begin
               emit       = 1'b1;
               res.value  = {24'd0, CH_BSLASH};
               res.status = ST_INCOMPL;
            end else if (q_item.is_simple) begin
               emit          = 1'b1;
               res.value     = {25'd0, q_item.simple_val};
               res.char_used = 1'b1;
            end else if (q_item.is_oct) begin
               acc_in   = {29'd0, q_item.ch[2:0]};
               count_in = 4'd1;
               mode_in  = MODE_OCT;
            end else if (q_item.is_x) begin
               acc_in   = '0;
               count_in = '0;
               mode_in  = MODE_HEX0;
            end else if (q_item.is_ucn_start) begin
               acc_in   = '0;
               count_in = '0;
               long_in  = q_item.ucn_long;
               mode_in  = MODE_UCN;
            end else begin
               emit          = 1'b1;
               res.value     = {24'd0, q_item.ch};
               res.status    = ST_UNKNOWN;
               res.char_used = 1'b1;
            end
         end
      endcase

      // after a result everything returns to its reset values
      if (emit) begin
         mode_in  = MODE_FIRST;
         acc_in   = '0;
         count_in = '0;
         long_in  = 1'b0;
      end

      valid_in  = valid_ff && !out_ready;
      result_in = result_ff;
      if (q_pop && emit) begin
         valid_in  = 1'b1;
         result_in = res;
      end
      if (!q_pop) begin
         mode_in  = mode_ff;
         acc_in   = acc_ff;
         count_in = count_ff;
         long_in  = long_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FIRST;
         acc_ff   <= '0;
         count_ff <= '0;
         long_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         long_ff  <= long_in;
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

endmodule

`default_nettype wire

// ===== rtl/c_escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// decodes the characters after a backslash in a c literal body
// ----------------------------------------------------------------------------
// usage:
//   req_chan carries one character (ch) per transfer, or an end-of-text
//   mark (end_of_text = 1, ch ignored). rsp_chan carries one result per
//   completed sequence: value, is_ucn, status and char_used. when
//   char_used is 0 the character of that transfer is not part of the
//   sequence and must be fed to the next stage again.
//   a result appears on rsp_chan after the transfer that completes it is
//   written into the queue and the back state machine has stepped it into
//   its result register.
//   throughput: one character per cycle while no result is held or
//   rsp_chan.ready is high, set by the back state machine, which steps
//   once per queued character.
//   reset (synchronous) empties the queue, drops any pending result and
//   returns the decoder to waiting for the first character.
//   when the receiver stalls, the result register holds; the queue keeps
//   taking characters until it fills, then req_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_sequence_decoder #(
   parameter int unsigned QUEUE_DEPTH = cesd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cesd_req_if.sink    req_chan,
   cesd_rsp_if.source  rsp_chan
);
   import cesd_pkg::*;

   // front to queue
   logic       q_push;
   logic       q_ready;
   item_type   q_in_item;

   // queue to back
   logic       q_valid;
   logic       q_pop;
   item_type   q_out_item;

   // back to result channel
   logic       out_valid;
   result_type out_result;

   // classify each character as it is accepted
   cesd_front u_front (
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_item   (q_in_item)
   );

   // decouples the front from a stalled back end
   cesd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_out_item)
   );

   // sequence state machine and result register
   cesd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_out_item),
      .q_pop      (q_pop),
      .out_valid  (out_valid),
      .out_result (out_result),
      .out_ready  (rsp_chan.ready)
   );

   assign rsp_chan.valid     = out_valid;
   assign rsp_chan.value     = out_result.value;
   assign rsp_chan.is_ucn    = out_result.is_ucn;
   assign rsp_chan.status    = out_result.status;
   assign rsp_chan.char_used = out_result.char_used;

   // an unknown escape always consumes its character
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_UNKNOWN |-> rsp_chan.char_used)
      else $error("unknown escape without char_used");

   // a ucn result is ok, short or a bad code point
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_ucn |->
         rsp_chan.status == ST_OK || rsp_chan.status == ST_SHORT
         || rsp_chan.status == ST_BADCP)
      else $error("ucn result with raw-only status");

   // a complete ucn always consumes its last digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_ucn && rsp_chan.status != ST_SHORT
         |-> rsp_chan.char_used)
      else $error("complete ucn without char_used");

   // the back end only steps when the queue holds an item
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== dv/c_escape_sequence_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_tb
// self-checking bench: feeds escape bodies through the decoder with random
// gaps on both channels and compares every decoded result, field by field,
// against an in-bench model of the escape state machine
// ----------------------------------------------------------------------------

module c_escape_sequence_decoder_tb;
   import cesd_pkg::*;

   // decoder modes as the bench tracks them
   typedef enum logic [2:0] {
      WAIT_FIRST,
      IN_OCTAL,
      HEX_FIRST,
      IN_HEX,
      IN_UCN
   } escape_mode_type;

   // expected results and the escape decoding that produces them
   class escape_scoreboard;
      escape_mode_type mode;
      logic [31:0]     acc;
      logic [3:0]      digits;
      logic [3:0]      ucn_len;
      result_type      expected_q[$];
      int              errors;
      int              decoded;
      int              ucn_count;
      int              status_seen[6];

      function new();
         clear();
      endfunction

      function void clear();
         mode    = WAIT_FIRST;
         acc     = '0;
         digits  = '0;
         ucn_len = UCN_SHORT_LEN;
      endfunction

      // hex digit test and value, in either letter case
      static function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
         v = '0;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c[3:0];
            return 1'b1;
         end
         if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void close_sequence(logic [31:0] v, logic ucn, status_type st, logic used);
         result_type r;
         r.value     = v;
         r.is_ucn    = ucn;
         r.status    = st;
         r.char_used = used;
         expected_q.push_back(r);
         clear();
      endfunction

      // one accepted character (or end-of-text mark)
      function void note_request(logic [7:0] c, logic eot);
         logic [3:0]  hv;
         logic        is_hex;
         logic        is_oct;
         logic        hit;
         logic [7:0]  sv;
         logic        bad;
         is_hex = !eot && hex_nibble(c, hv);
         is_oct = !eot && c >= CH_ZERO && c <= CH_SEVEN;
         case (mode)
            IN_OCTAL: begin
               if (!is_oct) begin
                  close_sequence(acc, 1'b0, ST_OK, 1'b0);
               end else begin
                  acc    = {acc[28:0], c[2:0]};
                  digits = digits + 4'd1;
                  if (digits >= OCT_MAX_DIGITS) close_sequence(acc, 1'b0, ST_OK, 1'b1);
               end
            end
            HEX_FIRST: begin
               if (!is_hex) begin
                  close_sequence({24'd0, CH_X}, 1'b0, ST_NOHEX, 1'b0);
               end else begin
                  acc  = {28'd0, hv};
                  mode = IN_HEX;
               end
            end
            IN_HEX: begin
               if (!is_hex) close_sequence(acc, 1'b0, ST_OK, 1'b0);
               else acc = {acc[27:0], hv};
            end
            IN_UCN: begin
               if (!is_hex) begin
                  close_sequence(acc, 1'b1, ST_SHORT, 1'b0);
               end else begin
                  acc    = {acc[27:0], hv};
                  digits = digits + 4'd1;
                  if (digits >= ucn_len) begin
                     bad = (acc >= SURR_LO && acc <= SURR_HI) || acc > CP_MAX;
                     close_sequence(acc, 1'b1, bad ? ST_BADCP : ST_OK, 1'b1);
                  end
               end
            end
            default: begin
               hit = 1'b1;
               sv  = c;
               case (c)
                  8'h27, 8'h22, 8'h3F, 8'h5C: sv = c;
                  "a":     sv = 8'd7;
                  "b":     sv = 8'd8;
                  "f":     sv = 8'd12;
                  "n":     sv = 8'd10;
                  "r":     sv = 8'd13;
                  "t":     sv = 8'd9;
                  "v":     sv = 8'd11;
                  default: hit = 1'b0;
               endcase
               if (eot) begin
                  close_sequence({24'd0, CH_BSLASH}, 1'b0, ST_INCOMPL, 1'b0);
               end else if (hit) begin
                  close_sequence({24'd0, sv}, 1'b0, ST_OK, 1'b1);
               end else if (is_oct) begin
                  acc    = {29'd0, c[2:0]};
                  digits = 4'd1;
                  mode   = IN_OCTAL;
               end else if (c == CH_X) begin
                  acc    = '0;
                  digits = '0;
                  mode   = HEX_FIRST;
               end else if (c == CH_LO_U || c == CH_UP_U) begin
                  acc     = '0;
                  digits  = '0;
                  ucn_len = (c == CH_LO_U) ? UCN_SHORT_LEN : UCN_LONG_LEN;
                  mode    = IN_UCN;
               end else begin
                  close_sequence({24'd0, c}, 1'b0, ST_UNKNOWN, 1'b1);
               end
            end
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // one accepted result against the oldest expectation
      function void check_result(logic [31:0] v, logic ucn, logic [2:0] st, logic used);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual value %h status %0d",
                     $time, v, st);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         decoded++;
         if (v !== want.value) begin
            $display("%0t: value mismatch, expected %h, actual %h", $time, want.value, v);
            errors++;
         end
         if (ucn !== want.is_ucn) begin
            $display("%0t: is_ucn mismatch, expected %b, actual %b", $time, want.is_ucn, ucn);
            errors++;
         end
         if (st !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
            errors++;
         end
         if (used !== want.char_used) begin
            $display("%0t: char_used mismatch, expected %b, actual %b",
                     $time, want.char_used, used);
            errors++;
         end
         status_seen[int'(want.status)]++;
         if (want.is_ucn) ucn_count++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   cesd_req_if req_chan ();
   cesd_rsp_if rsp_chan ();

   c_escape_sequence_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   escape_scoreboard sb;
   int sent;
   int send_calm;   // items left in a stretch without sender gaps
   int recv_calm;   // same for the receiver

   // simple escape letters, picked at random
   string simple_chars = "'\"?\\abfnrtv";

   always #1 clock = ~clock;

   // gap before an item: mostly random, now and then a run of items with no gap
   function automatic int draw_gap(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // hex digit character for a nibble, random letter case
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return CH_ZERO + 8'(n);
      return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(n) - 8'd10;
   endfunction

   // one transfer on the character channel; valid stays up across back-to-back items
   task automatic send_item(logic [7:0] c, logic eot);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.ch          <= c;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(c, eot);
      sent++;
   endtask

   task automatic send_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // ends a digit run: end of text, or a character that is no digit of the run
   task automatic send_stop(bit octal_run);
      logic [7:0] c;
      logic [3:0] hv;
      if ($urandom_range(0, 3) == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         do begin
            c = 8'($urandom_range(0, 255));
         end while (octal_run ? (c >= CH_ZERO && c <= CH_SEVEN)
                              : escape_scoreboard::hex_nibble(c, hv));
         send_item(c, 1'b0);
      end
   endtask

   // short hand-picked sequences: extremes and each special case once
   task automatic run_directed();
      send_item(8'h00, 1'b1);            // end of text right after the backslash
      send_text("n");                    // simple escape
      send_item(8'hFF, 1'b0);            // top byte, unknown escape
      send_text("777");                  // full octal run
      send_text("1");
      send_item(8'h00, 1'b1);            // octal cut by end of text
      send_text("xg");                   // hex with no digits
      send_text("x123456789z");          // hex run that wraps past 32 bits
      send_text("U00110000");            // code point above the unicode range
      send_text("u1");
      send_item(8'h00, 1'b1);            // short universal name
   endtask

   task automatic run_random();
      int         pick;
      int         n;
      int         i;
      int         len;
      int         cut;
      logic       long_name;
      logic [31:0] cp;
      while (sent < 1850) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_item(simple_chars[$urandom_range(0, 10)], 1'b0);
         end else if (pick < 14) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end else if (pick < 32) begin
            // octal: one to three digits, stopped early now and then
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_item(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
            if (n < 3) send_stop(1'b1);
         end else if (pick < 55) begin
            // hex: zero or more digits, then a stop
            send_item(CH_X, 1'b0);
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
            send_stop(1'b0);
         end else if (pick < 85) begin
            // universal name: random values and values near the surrogate range and the top code point
            case ($urandom_range(0, 4))
               0:       cp = $urandom;
               1:       cp = SURR_LO - 32'd1 + 32'($urandom_range(0, 2));
               2:       cp = SURR_HI - 32'd1 + 32'($urandom_range(0, 2));
               3:       cp = CP_MAX - 32'd1 + 32'($urandom_range(0, 2));
               default: cp = 32'($urandom_range(0, 16'hFFFF));
            endcase
            long_name = 1'($urandom_range(0, 1));
            len = long_name ? 8 : 4;
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
            send_item(long_name ? CH_UP_U : CH_LO_U, 1'b0);
            for (i = 0; i < cut; i++) send_item(hex_char(4'(cp >> (4 * (len - 1 - i)))), 1'b0);
            if (cut < len) send_stop(1'b0);
         end else begin
            // noise: any byte, some end-of-text marks
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 5) == 0));
         end
      end
   endtask

   // result side: random stalls, one check per transfer
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(recv_calm);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         sb.check_result(rsp_chan.value, rsp_chan.is_ucn, rsp_chan.status,
                         rsp_chan.char_used);
      end
   end

   initial begin
      sb        = new();
      sent      = 0;
      send_calm = 0;
      recv_calm = 0;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.ch          <= '0;
      req_chan.end_of_text <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random();
      req_chan.valid <= 1'b0;

      // drain, then give a stray result time to show up
      while (sb.pending() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending() > 0) begin
         $display("%0t: %0d results never arrived", $time, sb.pending());
         sb.errors++;
      end

      $display("covered %0d character transfers and %0d results (%0d universal names)",
               sent, sb.decoded, sb.ucn_count);
      $display("status mix: ok %0d, unknown %0d, incomplete %0d, no hex %0d, short %0d, bad cp %0d",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
